// ===== rtl/core/fcp_pkg.sv =====
// Package for the frame chunk packetizer: widths, constants, controller
// states and the command/status bundles shared by all core files.
// No dependencies.
package fcp_pkg;

  // Width of the message length field and the message offset counter.
  localparam int LENGTH_BITS = 24;
  // Chunk index and chunk total counters.
  localparam int CNT_W       = 24;
  localparam int PSIZE_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;

  localparam int HDR_BYTES   = 13;
  localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
  localparam logic [PSIZE_W-1:0] PAYLOAD_RESET = PSIZE_W'(1400 - HDR_BYTES);

  // Input item: data byte, frame number, type byte, length, padded to bytes.
  localparam int IN_FIELDS_W = BYTE_W + WORD_W + BYTE_W + LENGTH_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int FRAME_LSB   = BYTE_W;
  localparam int TYPE_LSB    = FRAME_LSB + WORD_W;
  localparam int LEN_LSB     = TYPE_LSB + BYTE_W;

  // Divider: (length + payload - 1) needs one bit more than the length.
  localparam int DIVD_W      = LENGTH_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(DIVD_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HDR,
    ST_DATA
  } fcp_state_e;

  typedef struct packed {
    logic                 take;       // input item accepted this cycle
    logic                 start_msg;  // accepted item opens a message
    logic                 hdr_load;   // load one header byte into the output
    logic [HDR_IDX_W-1:0] hdr_idx;    // header byte position, 0 first
    logic                 data_load;  // load the data byte into the output
  } fcp_cmd_t;

  typedef struct packed {
    logic msg_start;    // message offset is zero
    logic chunk_start;  // byte in chunk is zero
    logic out_free;     // output register can take a byte
    logic div_done;     // chunk total is ready
  } fcp_sts_t;

endpackage

// ===== rtl/core/fcp_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the chunk total.
// Depends on fcp_pkg.
module fcp_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fcp_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [fcp_pkg::PSIZE_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [fcp_pkg::DIVD_W-1:0]   quotient_o
);
  import fcp_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVD_W-1:0]    dvd_q, dvd_d;
  logic [PSIZE_W-1:0]   rem_q, rem_d;
  logic [PSIZE_W-1:0]   dsr_q, dsr_d;
  logic [PSIZE_W:0]     rem_sh;
  logic [PSIZE_W:0]     rem_sub;
  logic                 ge;

  // The quotient bits shift into the dividend register as it empties.
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = rem_sh >= {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[PSIZE_W-1:0] : rem_sh[PSIZE_W-1:0];
      dvd_d = {dvd_q[DIVD_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== rtl/core/fcp_datapath.sv =====
// Datapath of the packetizer: message latches, chunk counters, header byte
// selection and the output register. Depends on fcp_pkg and fcp_divider.
module fcp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcp_pkg::PSIZE_W-1:0]    cfg_wdata_i,
  input  logic [fcp_pkg::IN_DATA_W-1:0]  in_data_i,
  input  fcp_pkg::fcp_cmd_t              cmd_i,
  output fcp_pkg::fcp_sts_t              sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [fcp_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           out_pkt_last_o,
  output logic                           out_run_last_o
);
  import fcp_pkg::*;

  localparam int HDR_W = HDR_BYTES * BYTE_W;

  logic [PSIZE_W-1:0]     pmax_q;
  logic [PSIZE_W-1:0]     psize;
  logic [LENGTH_BITS-1:0] off_q, off_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [PSIZE_W-1:0]     bic_q, bic_d;
  logic [CNT_W-1:0]       total_q;
  logic [WORD_W-1:0]      frame_q;
  logic [BYTE_W-1:0]      type_q;
  logic [LENGTH_BITS-1:0] len_q;
  logic [BYTE_W-1:0]      data_q;
  logic [LENGTH_BITS-1:0] len_in;
  logic [LENGTH_BITS-1:0] len_in_eff;
  logic [LENGTH_BITS-1:0] len_eff;
  logic [DIVD_W-1:0]      dividend;
  logic                   div_done;
  logic [DIVD_W-1:0]      quotient;
  logic                   pkt_end;
  logic                   msg_end;
  logic [HDR_W-1:0]       hdr_vec;
  logic [HDR_IDX_W-1:0]   hdr_rev;
  logic [BYTE_W-1:0]      hdr_byte;
  logic                   ovalid_q, ovalid_d;
  logic [BYTE_W-1:0]      obyte_q;
  logic                   oplast_q;
  logic                   orlast_q;

  // A payload size of zero acts as one, and so does a zero length.
  assign psize      = (pmax_q == '0) ? PSIZE_W'(1) : pmax_q;
  assign len_in     = in_data_i[LEN_LSB +: LENGTH_BITS];
  assign len_in_eff = (len_in == '0) ? LENGTH_BITS'(1) : len_in;
  assign len_eff    = (len_q == '0) ? LENGTH_BITS'(1) : len_q;
  assign dividend   = DIVD_W'(len_in_eff) + DIVD_W'(psize) - DIVD_W'(1);

  fcp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_msg),
    .dividend_i (dividend),
    .divisor_i  (psize),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign pkt_end = ({1'b0, bic_q} + (PSIZE_W+1)'(1)) >= {1'b0, psize};
  assign msg_end = ({1'b0, off_q} + (LENGTH_BITS+1)'(1)) >= {1'b0, len_eff};

  // Header: frame number, chunk index, chunk total (big-endian), type byte.
  assign hdr_vec  = {frame_q, WORD_W'(cnt_q), WORD_W'(total_q), type_q};
  assign hdr_rev  = HDR_IDX_W'(HDR_BYTES - 1) - cmd_i.hdr_idx;
  assign hdr_byte = hdr_vec[{hdr_rev, 3'b000} +: BYTE_W];

  always_comb begin
    off_d = off_q;
    cnt_d = cnt_q;
    bic_d = bic_q;
    if (cmd_i.start_msg) begin
      cnt_d = '0;
      bic_d = '0;
    end else if (cmd_i.data_load) begin
      if (msg_end) begin
        off_d = '0;
        cnt_d = '0;
        bic_d = '0;
      end else begin
        off_d = off_q + LENGTH_BITS'(1);
        if (pkt_end) begin
          bic_d = '0;
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          bic_d = bic_q + PSIZE_W'(1);
        end
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.hdr_load || cmd_i.data_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmax_q   <= PAYLOAD_RESET;
      off_q    <= '0;
      cnt_q    <= '0;
      bic_q    <= '0;
      total_q  <= '0;
      frame_q  <= '0;
      type_q   <= '0;
      len_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pmax_q <= cfg_wdata_i;
      end
      off_q    <= off_d;
      cnt_q    <= cnt_d;
      bic_q    <= bic_d;
      ovalid_q <= ovalid_d;
      if (cmd_i.start_msg) begin
        frame_q <= in_data_i[FRAME_LSB +: WORD_W];
        type_q  <= in_data_i[TYPE_LSB +: BYTE_W];
        len_q   <= len_in;
      end
      if (div_done) begin
        total_q <= quotient[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      data_q <= in_data_i[BYTE_W-1:0];
    end
    if (cmd_i.hdr_load) begin
      obyte_q  <= hdr_byte;
      oplast_q <= 1'b0;
      orlast_q <= 1'b0;
    end else if (cmd_i.data_load) begin
      obyte_q  <= data_q;
      oplast_q <= pkt_end || msg_end;
      orlast_q <= 1'b1;
    end
  end

  assign sts_o.msg_start   = (off_q == '0);
  assign sts_o.chunk_start = (bic_q == '0);
  assign sts_o.out_free    = !ovalid_q || out_ready_i;
  assign sts_o.div_done    = div_done;

  assign out_valid_o    = ovalid_q;
  assign out_byte_o     = obyte_q;
  assign out_pkt_last_o = oplast_q;
  assign out_run_last_o = orlast_q;

endmodule

// ===== rtl/core/fcp_ctrl.sv =====
// Controller of the packetizer: accepts an item, waits for the chunk total,
// steps through the header bytes and releases the data byte. Depends on fcp_pkg.
module fcp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fcp_pkg::fcp_sts_t  sts_i,
  output fcp_pkg::fcp_cmd_t  cmd_o
);
  import fcp_pkg::*;

  fcp_state_e           state_q, state_d;
  logic [HDR_IDX_W-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    in_ready_o      = 1'b0;
    cmd_o.take      = 1'b0;
    cmd_o.start_msg = 1'b0;
    cmd_o.hdr_load  = 1'b0;
    cmd_o.hdr_idx   = idx_q;
    cmd_o.data_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take      = 1'b1;
          cmd_o.start_msg = sts_i.msg_start;
          idx_d           = '0;
          if (sts_i.msg_start) begin
            state_d = ST_DIV;
          end else if (sts_i.chunk_start) begin
            state_d = ST_HDR;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DIV: begin
        // A new message always opens with a chunk header.
        if (sts_i.div_done) begin
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        if (sts_i.out_free) begin
          cmd_o.hdr_load = 1'b1;
          if (idx_q == HDR_IDX_W'(HDR_BYTES - 1)) begin
            idx_d   = '0;
            state_d = ST_DATA;
          end else begin
            idx_d = idx_q + HDR_IDX_W'(1);
          end
        end
      end
      ST_DATA: begin
        if (sts_i.out_free) begin
          cmd_o.data_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/frame_chunk_packetizer_unit.sv =====
// Frame chunk packetizer: cuts a byte stream into packets with 13-byte headers.
// Mid-chunk an item is accepted and latched, and its byte then enters the output register
// once the output is free. A chunk start first adds the 13 header bytes, and a message
// start also adds the divider run for the chunk total before them. The next item is taken
// only after the data byte is loaded. Output stalls hold the header and data steps.
// Reset (rst_ni low, async) clears all counters and latches and sets the payload size to 1387.
module frame_chunk_packetizer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fcp_pkg::PSIZE_W-1:0]    cfg_wdata_i,    // chunk_payload_max
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // data_byte [7:0], frame_number [39:8], payload_type [47:40],
  // payload_length [71:48]
  input  logic [fcp_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [fcp_pkg::BYTE_W-1:0]     m_axis_tdata_o, // out_byte [7:0]
  output logic                           m_axis_tlast_o, // packet_last
  output logic                           m_axis_tuser_o  // run_last [0]
);
  import fcp_pkg::*;

  fcp_cmd_t cmd;
  fcp_sts_t sts;

  fcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcp_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_data_i      (s_axis_tdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_byte_o     (m_axis_tdata_o),
    .out_pkt_last_o (m_axis_tlast_o),
    .out_run_last_o (m_axis_tuser_o)
  );

  // Each accepted item is worked off before the next one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |=> !cmd.take)
    else $error("item accepted in consecutive cycles");

  // A byte is never loaded over one that is still waiting downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.hdr_load || cmd.data_load) |-> sts.out_free)
    else $error("output byte overwritten");

  // The data byte closes the results of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.data_load |=> (m_axis_tvalid_o && m_axis_tuser_o))
    else $error("data byte not flagged as the item's last result");

endmodule

// ===== tb/tb_frame_chunk_packetizer_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for frame_chunk_packetizer_unit: a directed table, then random messages
// under random payload sizes, with every output item checked against a packetizer predictor.
// Depends on fcp_pkg and the unit itself.
module tb_frame_chunk_packetizer_unit;
  import fcp_pkg::*;

  localparam int RAND_ITEMS = 230;
  localparam int DIR_ROWS   = 25;

  typedef enum logic {
    ROW_ITEM,
    ROW_SIZE
  } row_kind_e;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKS
  } rx_mode_e;

  typedef struct packed {
    logic [BYTE_W-1:0] obyte;
    logic              pkt_last;
    logic              run_last;
  } pkt_byte_t;

  // A zero count means the row is checked against the predictor only.
  typedef struct packed {
    row_kind_e           kind;
    logic [PSIZE_W-1:0]  size;
    logic [BYTE_W-1:0]   data;
    logic [WORD_W-1:0]   frame;
    logic [BYTE_W-1:0]   ptype;
    logic [LENGTH_BITS-1:0] plen;
    logic [3:0]          n_exp;
    logic                last_exp;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [PSIZE_W-1:0]    cfg_wdata = '0;
  logic                  s_valid   = 1'b0;
  logic [IN_DATA_W-1:0]  s_data    = '0;
  logic                  m_ready   = 1'b0;
  logic                  s_ready;
  logic                  m_valid;
  logic [BYTE_W-1:0]     m_data;
  logic                  m_last;
  logic                  m_user;

  // Predictor state.
  logic [PSIZE_W-1:0]     size_reg;
  logic [LENGTH_BITS-1:0] msg_off;
  logic [CNT_W-1:0]       chunk_num;
  logic [CNT_W-1:0]       chunk_cnt;
  logic [PSIZE_W-1:0]     chunk_pos;
  logic [WORD_W-1:0]      frame_lat;
  logic [BYTE_W-1:0]      type_lat;
  logic [LENGTH_BITS-1:0] len_lat;

  pkt_byte_t pending_bytes[$];
  pkt_byte_t mon_got;
  pkt_byte_t mon_want;
  int        err_cnt    = 0;
  int        burst_left = 0;
  int        rx_left    = 0;
  rx_mode_e  rx_mode    = RX_OPEN;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_ITEM, 16'd0,     8'h00, 32'h0000_0000, 8'h00, 24'd1,        4'd14, 1'b1},
    '{ROW_ITEM, 16'd0,     8'hFF, 32'hFFFF_FFFF, 8'hFF, 24'd0,        4'd14, 1'b1},
    '{ROW_ITEM, 16'd0,     8'h5A, 32'h1234_5678, 8'h01, 24'd3,        4'd14, 1'b0},
    '{ROW_ITEM, 16'd0,     8'hA5, 32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF,  4'd1,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h3C, 32'h0000_0000, 8'h00, 24'd0,        4'd1,  1'b1},
    '{ROW_SIZE, 16'd1,     8'h00, 32'h0000_0000, 8'h00, 24'd0,        4'd0,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h01, 32'h89AB_CDEF, 8'h00, 24'd2,        4'd14, 1'b1},
    '{ROW_ITEM, 16'd0,     8'h02, 32'h0000_0000, 8'h00, 24'd0,        4'd14, 1'b1},
    '{ROW_SIZE, 16'd0,     8'h00, 32'h0000_0000, 8'h00, 24'd0,        4'd0,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h80, 32'h0000_0001, 8'h7F, 24'd2,        4'd14, 1'b1},
    '{ROW_ITEM, 16'd0,     8'h7F, 32'h0000_0000, 8'h00, 24'd0,        4'd14, 1'b1},
    '{ROW_SIZE, 16'hFFFF,  8'h00, 32'h0000_0000, 8'h00, 24'd0,        4'd0,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h11, 32'h0F1E_2D3C, 8'h02, 24'd2,        4'd14, 1'b0},
    '{ROW_ITEM, 16'd0,     8'h22, 32'h0000_0000, 8'h00, 24'd0,        4'd1,  1'b1},
    '{ROW_SIZE, 16'd65522, 8'h00, 32'h0000_0000, 8'h00, 24'd0,        4'd0,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h33, 32'hF0E1_D2C3, 8'h80, 24'd1,        4'd14, 1'b1},
    '{ROW_SIZE, 16'd5,     8'h00, 32'h0000_0000, 8'h00, 24'd0,        4'd0,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h40, 32'h1357_2468, 8'h01, 24'd5,        4'd14, 1'b0},
    '{ROW_ITEM, 16'd0,     8'h41, 32'h0000_0000, 8'h00, 24'd0,        4'd1,  1'b0},
    // Shrinking the payload size mid-message ends the chunk at once, and the
    // chunk index then runs past the latched total.
    '{ROW_SIZE, 16'd1,     8'h00, 32'h0000_0000, 8'h00, 24'd0,        4'd0,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h42, 32'h0000_0000, 8'h00, 24'd0,        4'd1,  1'b1},
    '{ROW_ITEM, 16'd0,     8'h43, 32'h0000_0000, 8'h00, 24'd0,        4'd14, 1'b1},
    '{ROW_ITEM, 16'd0,     8'h44, 32'h0000_0000, 8'h00, 24'd0,        4'd14, 1'b1},
    '{ROW_SIZE, PAYLOAD_RESET, 8'h00, 32'h0000_0000, 8'h00, 24'd0,    4'd0,  1'b0},
    '{ROW_ITEM, 16'd0,     8'h6B, 32'h2468_ACE0, 8'h00, 24'd1,        4'd0,  1'b0}
  };

  frame_chunk_packetizer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

  function automatic void push_be_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) begin
      pending_bytes.push_back('{w[8*i +: 8], 1'b0, 1'b0});
    end
  endfunction

  // Queues the packet bytes that one payload byte produces; returns their count.
  function automatic int packetize(input logic [7:0] d, input logic [31:0] fr,
                                   input logic [7:0] ty, input logic [23:0] ln,
                                   output logic pl);
    int unsigned psize;
    int unsigned eff_len;
    logic        msg_end;
    int          n;
    n = 1;
    psize = (size_reg == 0) ? 1 : size_reg;
    if (msg_off == 0) begin
      frame_lat = fr;
      type_lat  = ty;
      len_lat   = ln;
      eff_len   = (ln == 0) ? 1 : ln;
      chunk_cnt = CNT_W'((eff_len + psize - 1) / psize);
      chunk_num = '0;
      chunk_pos = '0;
    end
    eff_len = (len_lat == 0) ? 1 : len_lat;
    if (chunk_pos == 0) begin
      push_be_word(frame_lat);
      push_be_word(32'(chunk_num));
      push_be_word(32'(chunk_cnt));
      pending_bytes.push_back('{type_lat, 1'b0, 1'b0});
      n += HDR_BYTES;
    end
    msg_end = (msg_off + 1 >= eff_len);
    pl = msg_end || (chunk_pos + 1 >= psize);
    pending_bytes.push_back('{d, pl, 1'b1});
    if (msg_end) begin
      msg_off   = '0;
      chunk_num = '0;
      chunk_pos = '0;
    end else begin
      msg_off = msg_off + 1'b1;
      if (pl) begin
        chunk_pos = '0;
        chunk_num = chunk_num + 1'b1;
      end else begin
        chunk_pos = chunk_pos + 1'b1;
      end
    end
    return n;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // tvalid still high, so the caller must drive the next item or settle at once.
  task automatic send_item(input logic [7:0] d, input logic [31:0] fr,
                           input logic [7:0] ty, input logic [23:0] ln,
                           output int n, output logic pl);
    logic [IN_DATA_W-1:0] word;
    int                   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    word = '0;
    word[0 +: BYTE_W]             = d;
    word[FRAME_LSB +: WORD_W]     = fr;
    word[TYPE_LSB +: BYTE_W]      = ty;
    word[LEN_LSB +: LENGTH_BITS]  = ln;
    s_valid <= 1'b1;
    s_data  <= word;
    do @(posedge clk_i); while (!s_ready);
    n = packetize(d, fr, ty, ln, pl);
    @(negedge clk_i);
  endtask

  // Waits until every queued byte has come out, then lets the block go quiet.
  task automatic settle();
    s_valid <= 1'b0;
    burst_left = 0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_size(input logic [PSIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    size_reg = v;
  endtask

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_ready <= 1'b1;
      RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
      default:   m_ready <= rx_left[3];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      mon_got = '{m_data, m_last, m_user};
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected item: byte %h last %b run %b", $time,
                 mon_got.obyte, mon_got.pkt_last, mon_got.run_last);
        err_cnt++;
      end else begin
        mon_want = pending_bytes.pop_front();
        if (mon_got !== mon_want) begin
          $display("%0t: mismatch: expected byte %h last %b run %b, got byte %h last %b run %b",
                   $time, mon_want.obyte, mon_want.pkt_last, mon_want.run_last,
                   mon_got.obyte, mon_got.pkt_last, mon_got.run_last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int          n;
    logic        pl;
    int          rand_sent;
    int          phase_len;
    int unsigned msg_left;
    logic [23:0] ln;
    logic [15:0] size_pick;

    size_reg  = PAYLOAD_RESET;
    msg_off   = '0;
    chunk_num = '0;
    chunk_cnt = '0;
    chunk_pos = '0;
    frame_lat = '0;
    type_lat  = '0;
    len_lat   = '0;
    rand_sent = 0;
    msg_left  = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].kind == ROW_SIZE) begin
        settle();
        write_size(dir_table[r].size);
      end else begin
        send_item(dir_table[r].data, dir_table[r].frame, dir_table[r].ptype,
                  dir_table[r].plen, n, pl);
        if (dir_table[r].n_exp != 0 &&
            (n != dir_table[r].n_exp || pl != dir_table[r].last_exp)) begin
          $display("%0t: row %0d: expected %0d items ending with last %b, predicted %0d/%b",
                   $time, r, dir_table[r].n_exp, dir_table[r].last_exp, n, pl);
          err_cnt++;
        end
      end
    end
    settle();

    // Random phases; a phase may end inside a message, so size changes also
    // land mid-message.
    while (rand_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       size_pick = 16'd0;
          1:       size_pick = 16'd1;
          2:       size_pick = 16'hFFFF;
          3:       size_pick = 16'd65522;
          4:       size_pick = PAYLOAD_RESET;
          default: size_pick = 16'($urandom_range(2, 20));
        endcase
        write_size(size_pick);
      end
      phase_len = $urandom_range(8, 40);
      repeat (phase_len) begin
        if (msg_left == 0) begin
          case ($urandom_range(0, 9))
            0:       ln = 24'd0;
            1:       ln = 24'($urandom_range(31, 70));
            default: ln = 24'($urandom_range(1, 30));
          endcase
          msg_left = (ln == 0) ? 1 : ln;
        end else begin
          ln = 24'($urandom);
        end
        send_item(8'($urandom), $urandom, 8'($urandom), ln, n, pl);
        msg_left--;
        rand_sent++;
      end
      settle();
    end

    // Close the open message, then start one of the longest length under the
    // smallest payload size; it is left open at the end of the run.
    while (msg_left != 0) begin
      send_item(8'($urandom), $urandom, 8'($urandom), 24'($urandom), n, pl);
      msg_left--;
    end
    settle();
    write_size(16'd1);
    send_item(8'($urandom), $urandom, 8'($urandom), 24'hFF_FFFF, n, pl);
    repeat (2) send_item(8'($urandom), $urandom, 8'($urandom), 24'($urandom), n, pl);
    settle();
    repeat (40) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
